/* rtl/waypoint_bearing_range_core_assert.svh */
// Assertion macros shared by the waypoint bearing/range RTL.
`ifndef WAYPOINT_BEARING_RANGE_CORE_ASSERT_SVH
`define WAYPOINT_BEARING_RANGE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define WBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/wbr_pkg.sv */
// Package: types, constants and arctangent table for the waypoint bearing/range core.
package wbr_pkg;

  localparam int CordicStagesDef = 16;
  localparam int CoordBitsDef    = 16;
  localparam int TabLen          = 24;
  localparam int CfgIdxW         = 1;
  localparam int CfgDataW        = 15;

  localparam logic [CfgIdxW-1:0] RegPosTol = 1'd0;
  localparam logic [CfgIdxW-1:0] RegAngTol = 1'd1;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_dir_e;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic        [15:0] compass_bearing;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
  } in_word_t;

  typedef struct packed {
    logic               at_destination;
    logic signed [15:0] heading_error;
    logic        [1:0]  turn_dir;
    logic        [16:0] range_to_goal;
    logic        [9:0]  turn_ms;
    logic        [19:0] drive_ms;
  } out_word_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
      5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
      5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
      5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
      5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
      5'd21: r = 22'd2;       5'd22: r = 22'd1;       default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/wbr_cordic.sv */
// Pipelined vectoring CORDIC: one rotation stage per register stage.
module wbr_cordic #(
  parameter int CordicStages = wbr_pkg::CordicStagesDef,
  parameter int XW           = 28,
  parameter int TagW         = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [31:0]   z_i,
  input  logic [TagW-1:0]      tag_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [31:0]   z_o,
  output logic [TagW-1:0]      tag_o
);

  localparam int N = (CordicStages > wbr_pkg::TabLen) ? wbr_pkg::TabLen : CordicStages;

  logic                 v_q   [N+1];
  logic signed [XW-1:0] x_q   [N+1];
  logic signed [XW-1:0] y_q   [N+1];
  logic signed [31:0]   z_q   [N+1];
  logic [TagW-1:0]      tag_q [N+1];

  always_comb begin
    v_q[0]   = valid_i;
    x_q[0]   = x_i;
    y_q[0]   = y_i;
    z_q[0]   = z_i;
    tag_q[0] = tag_i;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [XW-1:0] xs, ys;
    logic signed [31:0]   a;
    assign xs = x_q[g] >>> g;
    assign ys = y_q[g] >>> g;
    assign a  = 32'(wbr_pkg::atan_lut(5'(g)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[g+1] <= tag_q[g];
      if (!y_q[g][XW-1]) begin
        x_q[g+1] <= x_q[g] + ys;
        y_q[g+1] <= y_q[g] - xs;
        z_q[g+1] <= z_q[g] + a;
      end else begin
        x_q[g+1] <= x_q[g] - ys;
        y_q[g+1] <= y_q[g] + xs;
        z_q[g+1] <= z_q[g] - a;
      end
    end
  end

  assign valid_o = v_q[N];
  assign x_o     = x_q[N];
  assign z_o     = z_q[N];
  assign tag_o   = tag_q[N];

endmodule

/* rtl/waypoint_bearing_range_core.sv */
// Top level: waypoint bearing and range core.
//
// Usage: present an input word on in_i with start high; it is taken at any
// edge where busy is low. busy stays low, so a new word can enter every
// cycle. Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 position tolerance, 1 angle tolerance); write only while idle.
// Each result appears on out_o for one cycle with done_o high, in input
// order. Stages: differences, prescale and quadrant fold, one register per
// CORDIC rotation (CORDIC_STAGES, capped at 24), then gain multiply, angle
// rounding, error wrap, time products and their rounding stages. Throughput
// is one word per cycle, set by the fully pipelined CORDIC. The receiver
// cannot stall; results must be taken when shown. Reset clears all valid
// bits and restores the tolerances to 10 and 100; payload registers are not
// reset.
`include "waypoint_bearing_range_core_assert.svh"
module waypoint_bearing_range_core #(
  parameter int CORDIC_STAGES = wbr_pkg::CordicStagesDef,
  parameter int COORD_BITS    = wbr_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  wbr_pkg::in_word_t            in_i,
  output logic                         done_o,
  output wbr_pkg::out_word_t           out_o,
  input  logic                         cfg_we_i,
  input  logic [wbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbr_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CB = (COORD_BITS > 16) ? 16 : COORD_BITS;  // bits that carry data
  localparam bit ZeroExt = COORD_BITS > 16;  // wide coordinates read the field as unsigned
  localparam int DW = CB + 1;         // difference width
  localparam int XW = DW + 8 + 3;     // prescaled, plus CORDIC growth

  assign busy = 1'b0;

  // Configuration registers.
  logic [9:0]  pos_tol_q;
  logic [14:0] ang_tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_tol_q <= 10'd10;
      ang_tol_q <= 15'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbr_pkg::RegPosTol: pos_tol_q <= cfg_data_i[9:0];
        wbr_pkg::RegAngTol: ang_tol_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Stage 1: differences, arrival check, heading from bearing.
  logic                 take;
  logic signed [CB-1:0] rx, ry, tx, ty;
  logic signed [DW-1:0] dx_d, dy_d;
  logic [DW-1:0]        adx, ady;
  logic [15:0]          cb_r;
  logic [16:0]          hd_a;
  assign take = start && !busy;
  assign rx = in_i.robot_x[CB-1:0];
  assign ry = in_i.robot_y[CB-1:0];
  assign tx = in_i.dest_x[CB-1:0];
  assign ty = in_i.dest_y[CB-1:0];
  assign dx_d = ZeroExt ? DW'($unsigned(tx)) - DW'($unsigned(rx)) : DW'(tx) - DW'(rx);
  assign dy_d = ZeroExt ? DW'($unsigned(ty)) - DW'($unsigned(ry)) : DW'(ty) - DW'(ry);
  assign adx  = dx_d[DW-1] ? DW'(-dx_d) : DW'(dx_d);
  assign ady  = dy_d[DW-1] ? DW'(-dy_d) : DW'(dy_d);
  assign cb_r = (in_i.compass_bearing >= 16'd36000) ? in_i.compass_bearing - 16'd36000
                                                     : in_i.compass_bearing;
  assign hd_a = 17'd45000 - 17'(cb_r);

  logic                 v1_q, arr1_q;
  logic signed [DW-1:0] dx1_q, dy1_q;
  logic [15:0]          hd1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= take;
  end
  always_ff @(posedge clk_i) begin
    dx1_q  <= dx_d;
    dy1_q  <= dy_d;
    arr1_q <= ({1'b0, adx} < (DW+1)'(pos_tol_q)) && ({1'b0, ady} < (DW+1)'(pos_tol_q));
    hd1_q  <= (hd_a >= 17'd36000) ? 16'(hd_a - 17'd36000) : hd_a[15:0];
  end

  // Stage 2: prescale and fold the left half plane.
  logic signed [XW-1:0] px, py, x2_d, y2_d;
  logic signed [31:0]   z2_d;
  assign px = XW'(dx1_q) <<< 8;
  assign py = XW'(dy1_q) <<< 8;
  always_comb begin
    x2_d = px; y2_d = py; z2_d = '0;
    if (dx1_q[DW-1]) begin
      if (!dy1_q[DW-1]) begin
        x2_d = py; y2_d = -px; z2_d = 32'sd5898240;
      end else begin
        x2_d = -py; y2_d = px; z2_d = -32'sd5898240;
      end
    end
  end

  localparam int TagW = 1 + 1 + 16;  // arrived, zero vector, heading
  logic                 v2_q;
  logic signed [XW-1:0] x2_q, y2_q;
  logic signed [31:0]   z2_q;
  logic [TagW-1:0]      tag2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    x2_q   <= x2_d;
    y2_q   <= y2_d;
    z2_q   <= z2_d;
    tag2_q <= {arr1_q, (dx1_q == '0) && (dy1_q == '0), hd1_q};
  end

  logic                 vc;
  logic signed [XW-1:0] xc;
  logic signed [31:0]   zc;
  logic [TagW-1:0]      tagc;
  wbr_cordic #(.CordicStages(CORDIC_STAGES), .XW(XW), .TagW(TagW)) u_cordic (
    .clk_i, .rst_ni, .valid_i(v2_q), .x_i(x2_q), .y_i(y2_q), .z_i(z2_q), .tag_i(tag2_q),
    .valid_o(vc), .x_o(xc), .z_o(zc), .tag_o(tagc)
  );

  // Stage A: gain multiply and angle scaling.
  logic [XW-1:0] xpos;
  logic [31:0]   zabs;
  assign xpos = xc[XW-1] ? '0 : xc;
  assign zabs = zc[31] ? 32'(-zc) : 32'(zc);
  logic          va_q, za_neg_q;
  logic [47:0]   rp_q;
  logic [39:0]   zp_q;
  logic [TagW-1:0] taga_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= vc;
  end
  always_ff @(posedge clk_i) begin
    rp_q     <= 48'(xpos) * 48'd636751;
    zp_q     <= 40'(zabs) * 40'd100;
    za_neg_q <= zc[31];
    taga_q   <= tagc;
  end

  // Stage B: round range and angle, clamp, form the heading error.
  logic [19:0] rr;
  logic [23:0] ca;
  logic signed [15:0] th;
  assign rr = 20'((rp_q + 48'd134217728) >> 28);
  assign ca = 24'((zp_q + 40'd32768) >> 16);
  always_comb begin
    if (ca > 24'd18000) th = za_neg_q ? -16'sd18000 : 16'sd18000;
    else                th = za_neg_q ? -$signed(16'(ca)) : $signed(16'(ca));
    if (taga_q[16]) th = '0;
  end
  logic            vb_q;
  logic [16:0]     rng_b_q;
  logic signed [16:0] err_b_q;
  logic [TagW-1:0] tagb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    rng_b_q <= (rr > 20'd131071) ? 17'h1FFFF : rr[16:0];
    err_b_q <= 17'(th) - $signed({1'b0, taga_q[15:0]});
    tagb_q  <= taga_q;
  end

  // Stage C: wrap error, decide turn, select the turn magnitude.
  logic signed [16:0] ew;
  logic [15:0]        ae;
  always_comb begin
    ew = err_b_q;
    if (err_b_q > 17'sd18000)       ew = err_b_q - 17'sd36000;
    else if (err_b_q < -17'sd18000) ew = err_b_q + 17'sd36000;
  end
  assign ae = ew[16] ? 16'(-ew) : 16'(ew);
  logic        vc_q, arrc_q;
  logic signed [15:0] errc_q;
  logic [1:0]  tdc_q;
  logic [16:0] rngc_q;
  logic [15:0] aec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    arrc_q <= tagb_q[17];
    errc_q <= ew[15:0];
    rngc_q <= rng_b_q;
    if (ae >= 16'(ang_tol_q) && ew != '0) begin
      tdc_q <= ew[16] ? wbr_pkg::TURN_RIGHT : wbr_pkg::TURN_LEFT;
      aec_q <= ae;
    end else begin
      tdc_q <= wbr_pkg::TURN_NONE;
      aec_q <= '0;
    end
  end

  // Stage D: rounded numerators. turn = floor((ae*1e10 + 139118696398)/278237392796),
  // drive = floor((r*1e8 + 6591488)/13182976); both quotients follow in E and F.
  logic        vd_q, arrd_q;
  logic signed [15:0] errd_q;
  logic [1:0]  tdd_q;
  logic [16:0] rngd_q;
  logic [50:0] tnum_q;
  logic [43:0] dnum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    arrd_q <= arrc_q; errd_q <= errc_q; tdd_q <= tdc_q; rngd_q <= rngc_q;
    tnum_q <= 51'(aec_q) * 51'd10000000000 + 51'd139118696398;
    dnum_q <= 44'(rngc_q) * 44'd100000000 + 44'd6591488;
  end

  // Stage E: quotient estimates; exact fix-up in stage F.
  logic        ve_q, arre_q;
  logic signed [15:0] erre_q;
  logic [1:0]  tde_q;
  logic [16:0] rnge_q;
  logic [50:0] tnume_q;
  logic [43:0] dnume_q;
  logic [9:0]  tq_q;
  logic [19:0] dq_q;
  logic [63:0] tprod, dprod;
  // Underestimating reciprocals: floor(2^k/D) truncated, quotient off by at most one.
  assign tprod = 64'(tnum_q >> 18) * 64'd258978;    // 2^56/278237392796 ~ 258978.8
  assign dprod = 64'(dnum_q >> 12) * 64'd21351398;  // 2^48/13182976 ~ 21351398.7
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else         ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    arre_q <= arrd_q; erre_q <= errd_q; tde_q <= tdd_q; rnge_q <= rngd_q;
    tnume_q <= tnum_q; dnume_q <= dnum_q;
    tq_q <= 10'(tprod >> 38);
    dq_q <= 20'(dprod >> 36);
  end

  // Stage F: correct the estimates by compare and step.
  logic [50:0] tr0, tr1;
  logic [43:0] dr0, dr1;
  logic [9:0]  tq;
  logic [19:0] dq;
  always_comb begin
    tr0 = 51'(tq_q) * 51'd278237392796;
    tr1 = tr0 + 51'd278237392796;
    tq  = tq_q;
    if (tr0 > tnume_q)       tq = tq_q - 10'd1;
    else if (tr1 <= tnume_q) tq = tq_q + 10'd1;
    dr0 = 44'(dq_q) * 44'd13182976;
    dr1 = dr0 + 44'd13182976;
    dq  = dq_q;
    if (dr0 > dnume_q)       dq = dq_q - 20'd1;
    else if (dr1 <= dnume_q) dq = dq_q + 20'd1;
  end

  // Output word: zero every field but the flag on arrival.
  logic       vf_q;
  wbr_pkg::out_word_t out_d, out_q;
  always_comb begin
    out_d = '0;
    if (arre_q) begin
      out_d.at_destination = 1'b1;
    end else begin
      out_d.heading_error = erre_q;
      out_d.turn_dir      = tde_q;
      out_d.range_to_goal = rnge_q;
      out_d.turn_ms       = tq;
      out_d.drive_ms      = dq;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else         vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = vf_q;
  assign out_o  = out_q;

  `WBR_ASSERT_IMP(a_busy_low, clk_i, rst_ni, 1'b1, !busy)
  `WBR_ASSERT_IMP(a_arrived_zero, clk_i, rst_ni, done_o && out_o.at_destination, out_o.range_to_goal == '0 && out_o.turn_dir == wbr_pkg::TURN_NONE)
  `WBR_ASSERT_IMP(a_noturn_zero, clk_i, rst_ni, done_o && out_o.turn_dir == wbr_pkg::TURN_NONE, out_o.turn_ms == '0)
  `WBR_ASSERT_NEXT(a_valid_flow, clk_i, rst_ni, ve_q, done_o)

endmodule
